### rtl/vsar_pkg.sv
// Shared types and constants for the video scroll address registers.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vsar_pkg;

    // Request codes carried on req_type.
    typedef enum logic [3:0] {
        REQ_RESET      = 4'd0,
        REQ_CTRL_WRITE = 4'd1,
        REQ_STATUS     = 4'd2,
        REQ_SCROLL     = 4'd3,
        REQ_ADDR       = 4'd4,
        REQ_DATA       = 4'd5,
        REQ_INC_X      = 4'd6,
        REQ_INC_Y      = 4'd7,
        REQ_COPY_X     = 4'd8,
        REQ_COPY_Y     = 4'd9
    } req_kind_t;

    localparam int unsigned ADDR_W  = 15;
    localparam int unsigned FETCH_W = 14;

    localparam logic [4:0]         COARSE_MAX   = 5'd31;
    localparam logic [4:0]         ROW_LAST     = 5'd29;
    localparam logic [2:0]         FINE_MAX     = 3'd7;
    localparam logic [ADDR_W-1:0]  STEP_ONE     = 15'd1;
    localparam logic [ADDR_W-1:0]  STEP_ROW     = 15'd32;
    localparam logic [ADDR_W-1:0]  X_PARTS      = 15'h041F;
    localparam logic [ADDR_W-1:0]  Y_PARTS      = 15'h7BE0;
    localparam logic [FETCH_W-1:0] TILE_BASE    = 14'h2000;
    localparam logic [FETCH_W-1:0] ATTR_BASE    = 14'h23C0;

    // One request as held in the input register.
    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] data;
    } req_t;

    // One result as held in the output register.
    typedef struct packed {
        logic [ADDR_W-1:0]  current_address;
        logic [2:0]         fine_scroll_x;
        logic               toggle_state;
        logic [FETCH_W-1:0] tile_fetch_address;
        logic [FETCH_W-1:0] attr_fetch_address;
    } rsp_t;

endpackage

`default_nettype wire

### rtl/vsar_req_reg.sv
// Input register of the scroll address block: holds one request.
// Depends on vsar_pkg for the request type.
`default_nettype none

module vsar_req_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          advance,
    input  wire vsar_pkg::req_t req_in,
    output logic               held,
    output vsar_pkg::req_t     req_out
);
    import vsar_pkg::*;

    logic held_reg;
    logic held_next;
    req_t req_reg;

    // The slot fills on acceptance and empties when the request moves on.
    always_comb
    begin
        held_next = held_reg;
        if (load)
        begin
            held_next = 1'b1;
        end
        else if (advance)
        begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_in;
        end
    end

    assign held    = held_reg;
    assign req_out = req_reg;

endmodule

`default_nettype wire

### rtl/vsar_core.sv
// Scroll state registers and their combinational update for one request.
// Depends on vsar_pkg for request codes, constants and the result type.
`default_nettype none

module vsar_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire vsar_pkg::req_t req,
    output vsar_pkg::rsp_t     rsp
);
    import vsar_pkg::*;

    logic [ADDR_W-1:0] temp_reg;
    logic [ADDR_W-1:0] temp_next;
    logic [ADDR_W-1:0] live_reg;
    logic [ADDR_W-1:0] live_next;
    logic [2:0]        fine_x_reg;
    logic [2:0]        fine_x_next;
    logic              second_reg;
    logic              second_next;
    logic              row_step_reg;
    logic              row_step_next;
    logic [7:0]        d;
    logic [4:0]        coarse_y;

    assign d = req.data;

    // Next state for the request in the input register.
    always_comb
    begin
        temp_next     = temp_reg;
        live_next     = live_reg;
        fine_x_next   = fine_x_reg;
        second_next   = second_reg;
        row_step_next = row_step_reg;
        coarse_y      = live_reg[9:5];
        case (req_kind_t'(req.req_type))
            REQ_RESET:
            begin
                second_next   = 1'b0;
                row_step_next = 1'b0;
            end
            REQ_CTRL_WRITE:
            begin
                temp_next[11:10] = d[1:0];
                row_step_next    = d[2];
            end
            REQ_STATUS:
            begin
                second_next = 1'b0;
            end
            REQ_SCROLL:
            begin
                if (second_reg)
                begin
                    temp_next[9:5]   = d[7:3];
                    temp_next[14:12] = d[2:0];
                end
                else
                begin
                    temp_next[4:0] = d[7:3];
                    fine_x_next    = d[2:0];
                end
                second_next = ~second_reg;
            end
            REQ_ADDR:
            begin
                if (second_reg)
                begin
                    temp_next = {temp_reg[14:8], d};
                    live_next = {temp_reg[14:8], d};
                end
                else
                begin
                    temp_next = {1'b0, d[5:0], temp_reg[7:0]};
                end
                second_next = ~second_reg;
            end
            REQ_DATA:
            begin
                live_next = live_reg + (row_step_reg ? STEP_ROW : STEP_ONE);
            end
            REQ_INC_X:
            begin
                if (live_reg[4:0] == COARSE_MAX)
                begin
                    live_next[4:0] = 5'd0;
                    live_next[10]  = ~live_reg[10];
                end
                else
                begin
                    live_next[4:0] = live_reg[4:0] + 5'd1;
                end
            end
            REQ_INC_Y:
            begin
                if (live_reg[14:12] != FINE_MAX)
                begin
                    live_next[14:12] = live_reg[14:12] + 3'd1;
                end
                else
                begin
                    live_next[14:12] = 3'd0;
                    if (coarse_y == ROW_LAST)
                    begin
                        live_next[9:5] = 5'd0;
                        live_next[11]  = ~live_reg[11];
                    end
                    else
                    begin
                        live_next[9:5] = coarse_y + 5'd1;
                    end
                end
            end
            REQ_COPY_X:
            begin
                live_next = (live_reg & ~X_PARTS) | (temp_reg & X_PARTS);
            end
            REQ_COPY_Y:
            begin
                live_next = (live_reg & ~Y_PARTS) | (temp_reg & Y_PARTS);
            end
            default:
            begin
                live_next = live_reg;
            end
        endcase
    end

    // State advances only when the request moves into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg     <= '0;
            live_reg     <= '0;
            fine_x_reg   <= '0;
            second_reg   <= 1'b0;
            row_step_reg <= 1'b0;
        end
        else if (step)
        begin
            temp_reg     <= temp_next;
            live_reg     <= live_next;
            fine_x_reg   <= fine_x_next;
            second_reg   <= second_next;
            row_step_reg <= row_step_next;
        end
    end

    // Result shows the state after the request, with derived fetch addresses.
    always_comb
    begin
        rsp.current_address    = live_next;
        rsp.fine_scroll_x      = fine_x_next;
        rsp.toggle_state       = second_next;
        rsp.tile_fetch_address = TILE_BASE | {2'b00, live_next[11:0]};
        rsp.attr_fetch_address = ATTR_BASE
                                 | {2'b00, live_next[11:10], 4'b0000,
                                    live_next[9:7], live_next[4:2]};
    end

endmodule

`default_nettype wire

### rtl/vsar_rsp_reg.sv
// Output register of the scroll address block: holds one result.
// Depends on vsar_pkg for the result type.
`default_nettype none

module vsar_rsp_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          taken,
    input  wire vsar_pkg::rsp_t rsp_in,
    output logic               held,
    output vsar_pkg::rsp_t     rsp_out
);
    import vsar_pkg::*;

    logic held_reg;
    logic held_next;
    rsp_t rsp_reg;

    // A new result overrides the departure of the old one in the same cycle.
    always_comb
    begin
        held_next = held_reg;
        if (load)
        begin
            held_next = 1'b1;
        end
        else if (taken)
        begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_in;
        end
    end

    assign held    = held_reg;
    assign rsp_out = rsp_reg;

endmodule

`default_nettype wire

### rtl/video_scroll_address_registers.sv
// Channel   | Handshake            | Payload
// request   | req_valid, req_stall | req_type, data
// result    | rsp_valid, rsp_stall | current_address, fine_scroll_x, toggle_state,
//           |                      | tile_fetch_address, attr_fetch_address
//
// One request per cycle is sustained while rsp_stall is low; the result appears when
// the request moves from the input register to the output register.
// The state update for a request is combinational between those registers.
// Reset (rst_n low) clears both addresses, fine X, the toggle and the step mode.
// A stalled result holds the output; one further request is accepted into the
// input register, after which req_stall rises until the result is taken.
// Top level of the video scroll address registers.
// Depends on vsar_pkg, vsar_req_reg, vsar_core and vsar_rsp_reg.
`default_nettype none

module video_scroll_address_registers (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [3:0]                    req_type,
    input  wire logic [7:0]                    data,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [vsar_pkg::ADDR_W-1:0]        current_address,
    output logic [2:0]                         fine_scroll_x,
    output logic                               toggle_state,
    output logic [vsar_pkg::FETCH_W-1:0]       tile_fetch_address,
    output logic [vsar_pkg::FETCH_W-1:0]       attr_fetch_address
);
    import vsar_pkg::*;

    req_t req_in;
    req_t req_held;
    rsp_t rsp_new;
    rsp_t rsp_held;
    logic in_held;
    logic out_held;
    logic accept;
    logic advance;
    logic taken;

    // Handshake control for the two-register pipeline.
    assign taken     = out_held && !rsp_stall;
    assign advance   = in_held && (!out_held || !rsp_stall);
    assign req_stall = in_held && !advance;
    assign accept    = req_valid && !req_stall;

    assign req_in = {req_type, data};

    vsar_req_reg u_req_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .advance (advance),
        .req_in  (req_in),
        .held    (in_held),
        .req_out (req_held)
    );

    vsar_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (req_held),
        .rsp   (rsp_new)
    );

    vsar_rsp_reg u_rsp_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .taken   (taken),
        .rsp_in  (rsp_new),
        .held    (out_held),
        .rsp_out (rsp_held)
    );

    // Result ports.
    assign rsp_valid          = out_held;
    assign current_address    = rsp_held.current_address;
    assign fine_scroll_x      = rsp_held.fine_scroll_x;
    assign toggle_state       = rsp_held.toggle_state;
    assign tile_fetch_address = rsp_held.tile_fetch_address;
    assign attr_fetch_address = rsp_held.attr_fetch_address;

endmodule

`default_nettype wire
